### rtl/mexp_pkg.sv
// Package for the modular exponentiation block: sequencer state type and codes.
// No dependencies; imported by modular_exponentiation.
package mexp_pkg;

  typedef logic [2:0] state_t;

  localparam state_t ST_IDLE = 3'd0;
  localparam state_t ST_RED  = 3'd1;
  localparam state_t ST_MUL  = 3'd2;
  localparam state_t ST_SQR  = 3'd3;
  localparam state_t ST_DONE = 3'd4;

endpackage

### rtl/mexp_if.sv
// Valid/ready channel interfaces for operand and result items.
// No dependencies; used by modular_exponentiation.
interface mexp_in_if #(
  parameter int WIDTH = 32
);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] base_value;
  logic [WIDTH-1:0] exponent_value;
  logic [WIDTH-1:0] modulus_value;

  modport source (output valid, base_value, exponent_value, modulus_value, input ready);
  modport sink   (input valid, base_value, exponent_value, modulus_value, output ready);
endinterface

interface mexp_out_if #(
  parameter int WIDTH = 32
);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] power_result;
  logic             modulus_zero_error;

  modport source (output valid, power_result, modulus_zero_error, input ready);
  modport sink   (input valid, power_result, modulus_zero_error, output ready);
endinterface

### rtl/modular_exponentiation.sv
// Modular exponentiation top level: bit-serial square-and-multiply sequencer.
// Depends on mexp_pkg and the channel interfaces in mexp_if.sv.
//
// One item at a time: an item is taken only while the sequencer is idle, and its
// result lands in an output register, so a new item may be taken while the last
// result still waits. All arithmetic runs through one interleaved modular
// multiply/add step that handles one operand bit per cycle. An item with a zero
// exponent or a zero modulus goes straight to completion. Otherwise the base is
// first reduced, then each exponent bit up to the highest set one takes a
// multiply when set plus a squaring that follows all but the last bit.
module modular_exponentiation #(
  parameter int WIDTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mexp_in_if.sink    in_i,
  mexp_out_if.source out_o
);
  import mexp_pkg::*;

  localparam int CW = $clog2(WIDTH);

  state_t           state_q, state_d;
  logic [WIDTH-1:0] m_q, m_d;
  logic [WIDTH-1:0] e_q, e_d;
  logic [WIDTH-1:0] base_q, base_d;
  logic [WIDTH-1:0] acc_q, acc_d;
  logic             err_q, err_d;
  logic [WIDTH-1:0] p_q, p_d;
  logic [WIDTH-1:0] b_q, b_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [WIDTH-1:0] res_q, res_d;
  logic             res_err_q, res_err_d;
  logic             out_vld_q, out_vld_d;

  logic [WIDTH:0]   dbl;
  logic [WIDTH-1:0] dbl_red;
  logic [WIDTH-1:0] addend;
  logic [WIDTH:0]   sum;
  logic [WIDTH-1:0] step;
  logic             last;
  logic             out_load;

  // One bit of interleaved reduction: p = (2p mod m + addend) mod m
  always_comb begin
    dbl     = {p_q, 1'b0};
    dbl_red = (dbl >= {1'b0, m_q}) ? WIDTH'(dbl - {1'b0, m_q}) : dbl[WIDTH-1:0];
    if (state_q == ST_RED) begin
      addend = {{(WIDTH-1){1'b0}}, b_q[WIDTH-1]};
    end else begin
      addend = b_q[WIDTH-1] ? base_q : '0;
    end
    sum  = {1'b0, dbl_red} + {1'b0, addend};
    step = (sum >= {1'b0, m_q}) ? WIDTH'(sum - {1'b0, m_q}) : sum[WIDTH-1:0];
  end

  assign last      = (cnt_q == '0);
  assign out_load  = (state_q == ST_DONE) && (!out_vld_q || out_o.ready);
  assign in_i.ready = (state_q == ST_IDLE);

  always_comb begin
    state_d   = state_q;
    m_d       = m_q;
    e_d       = e_q;
    base_d    = base_q;
    acc_d     = acc_q;
    err_d     = err_q;
    p_d       = p_q;
    b_d       = b_q;
    cnt_d     = cnt_q;
    res_d     = res_q;
    res_err_d = res_err_q;
    out_vld_d = out_vld_q;

    if (out_o.ready) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          m_d   = in_i.modulus_value;
          e_d   = in_i.exponent_value;
          b_d   = in_i.base_value;
          p_d   = '0;
          cnt_d = CW'(WIDTH - 1);
          err_d = 1'b0;
          priority if (in_i.exponent_value == '0) begin
            acc_d   = WIDTH'(1);
            state_d = ST_DONE;
          end else if (in_i.modulus_value == '0) begin
            acc_d   = '0;
            err_d   = 1'b1;
            state_d = ST_DONE;
          end else begin
            acc_d   = (in_i.modulus_value == WIDTH'(1)) ? '0 : WIDTH'(1);
            state_d = ST_RED;
          end
        end
      end
      ST_RED: begin
        p_d   = step;
        b_d   = {b_q[WIDTH-2:0], 1'b0};
        cnt_d = cnt_q - CW'(1);
        if (last) begin
          base_d = step;
          p_d    = '0;
          cnt_d  = CW'(WIDTH - 1);
          if (e_q[0]) begin
            b_d     = acc_q;
            state_d = ST_MUL;
          end else begin
            b_d     = step;
            state_d = ST_SQR;
          end
        end
      end
      ST_MUL: begin
        p_d   = step;
        b_d   = {b_q[WIDTH-2:0], 1'b0};
        cnt_d = cnt_q - CW'(1);
        if (last) begin
          acc_d = step;
          p_d   = '0;
          cnt_d = CW'(WIDTH - 1);
          b_d   = base_q;
          if (e_q[WIDTH-1:1] == '0) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_SQR;
          end
        end
      end
      ST_SQR: begin
        p_d   = step;
        b_d   = {b_q[WIDTH-2:0], 1'b0};
        cnt_d = cnt_q - CW'(1);
        if (last) begin
          base_d = step;
          e_d    = {1'b0, e_q[WIDTH-1:1]};
          p_d    = '0;
          cnt_d  = CW'(WIDTH - 1);
          if (e_q[1]) begin
            b_d     = acc_q;
            state_d = ST_MUL;
          end else begin
            b_d     = step;
            state_d = ST_SQR;
          end
        end
      end
      ST_DONE: begin
        if (out_load) begin
          res_d     = acc_q;
          res_err_d = err_q;
          out_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
      cnt_q     <= '0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q       <= m_d;
    e_q       <= e_d;
    base_q    <= base_d;
    acc_q     <= acc_d;
    err_q     <= err_d;
    p_q       <= p_d;
    b_q       <= b_d;
    res_q     <= res_d;
    res_err_q <= res_err_d;
  end

  assign out_o.valid              = out_vld_q;
  assign out_o.power_result       = res_q;
  assign out_o.modulus_zero_error = res_err_q;

`ifndef SYNTHESIS
  a_err_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_err_q |-> res_q == '0)
    else $error("error result carries nonzero power");

  a_operands_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL || state_q == ST_SQR) |-> (acc_q < m_q) && (base_q < m_q))
    else $error("operand not reduced below modulus");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == ST_DONE))
    else $error("result appeared outside completion");

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RED || state_q == ST_MUL || state_q == ST_SQR) |=> !in_i.valid ||
    !in_i.ready || state_q == ST_IDLE)
    else $error("item taken while sequencer busy");
`endif

endmodule
